FILE: design/bpd_pkg.sv
// Package for the BASIC program detokenizer: phases, controller states, text ROM.
// No dependencies.
package bpd_pkg;

	localparam int MaxTokenChars = 10;
	localparam int CharIdxW = $clog2(MaxTokenChars + 1);
	localparam logic [15:0] ProgramStart = 16'd16509;
	localparam logic [7:0] TokNewline = 8'd118;
	localparam logic [7:0] TokNumber = 8'd126;
	localparam logic [15:0] NumSkip = 16'd5;

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_BODY, PH_SKIPNUM, PH_SKIPLINE, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic parse;
		logic emit_char;
		logic next_char;
	} dp_cmd_t;

	typedef struct packed {
		logic emit_line;
		logic [CharIdxW-1:0] char_count;
	} dp_stat_t;

	function automatic string rom_text(input logic [7:0] b);
		case (b)
			8'd0: return " "; 8'd1: return "{1}"; 8'd2: return "{2}"; 8'd3: return "{7}";
			8'd4: return "{4}"; 8'd5: return "{5}"; 8'd6: return "{T}"; 8'd7: return "{E}";
			8'd8: return "{A}"; 8'd9: return "{D}"; 8'd10: return "{S}"; 8'd11: return "\"";
			8'd12: return "#"; 8'd13: return "$"; 8'd14: return ":"; 8'd15: return "?";
			8'd16: return "("; 8'd17: return ")"; 8'd18: return ">"; 8'd19: return "<";
			8'd20: return "="; 8'd21: return "+"; 8'd22: return "-"; 8'd23: return "*";
			8'd24: return "/"; 8'd25: return ";"; 8'd26: return ","; 8'd27: return ".";
			8'd64: return "RND"; 8'd65: return "INKEY$"; 8'd66: return "PI";
			8'd67: return "CALL "; 8'd68: return "ERR MSGS "; 8'd69: return "DPOKE ";
			8'd70: return "ERROR "; 8'd71: return "CHAR "; 8'd72: return " ";
			8'd73: return "TRACE "; 8'd74: return "DRAW "; 8'd75: return "UNDRAW ";
			8'd76: return "PROTECT "; 8'd77: return "EDIT "; 8'd78: return "AUTO ";
			8'd79: return "DEF PROC "; 8'd80: return "END PROC "; 8'd81: return "";
			8'd82: return "DELETE "; 8'd83: return "DO "; 8'd84: return "LOOP ";
			8'd85: return "EXIT "; 8'd86: return "UNTIL "; 8'd87: return "WHILE ";
			8'd88: return "WHEN "; 8'd89: return "INDENT "; 8'd90: return "RESEQ ";
			8'd91: return "OFF"; 8'd92: return "CURSOR "; 8'd93: return "DATA ";
			8'd94: return "RESTORE "; 8'd95: return "READ "; 8'd96: return "NOSTALGIC ";
			8'd97: return "USER "; 8'd98: return "*"; 8'd99: return "ON";
			8'd100: return "HOME "; 8'd101: return "BREAK "; 8'd102: return "DPEEK ";
			8'd103: return "LINE "; 8'd104: return "POP "; 8'd105: return "PUSH ";
			8'd106: return "CLR STACK "; 8'd107: return "DUP "; 8'd108: return "ELSE ";
			8'd109: return "END WHEN ";
			8'd128: return "[ ]"; 8'd129: return "{Q}"; 8'd130: return "{W}";
			8'd131: return "{6}"; 8'd132: return "{R}"; 8'd133: return "{8}";
			8'd134: return "{Y}"; 8'd135: return "{E}"; 8'd136: return "{H}";
			8'd137: return "{G}"; 8'd138: return "{F}"; 8'd139: return "[\"]";
			8'd140: return "[#]"; 8'd141: return "[$]"; 8'd142: return "[:]";
			8'd143: return "[?]"; 8'd144: return "[(]"; 8'd145: return "[)]";
			8'd146: return "[>]"; 8'd147: return "[<]"; 8'd148: return "[=]";
			8'd149: return "[+]"; 8'd150: return "[-]"; 8'd151: return "[*]";
			8'd152: return "[/]"; 8'd153: return "[;]"; 8'd154: return "[,]";
			8'd155: return "[.]";
			8'd192: return "\"\""; 8'd193: return "AT "; 8'd194: return "TAB ";
			8'd195: return "?"; 8'd196: return "CODE "; 8'd197: return "VAL ";
			8'd198: return "LEN "; 8'd199: return "SIN "; 8'd200: return "COS ";
			8'd201: return "TAN "; 8'd202: return "ASN "; 8'd203: return "ACS ";
			8'd204: return "ATN "; 8'd205: return "LN "; 8'd206: return "EXP ";
			8'd207: return "INT "; 8'd208: return "SQR "; 8'd209: return "SGN ";
			8'd210: return "ABS "; 8'd211: return "PEEK "; 8'd212: return "USR ";
			8'd213: return "STR$ "; 8'd214: return "CHR$ "; 8'd215: return "NOT ";
			8'd216: return "**"; 8'd217: return " OR "; 8'd218: return " AND ";
			8'd219: return "<="; 8'd220: return ">="; 8'd221: return "<>";
			8'd222: return " THEN "; 8'd223: return " TO "; 8'd224: return " STEP ";
			8'd225: return "LPRINT "; 8'd226: return "LLIST "; 8'd227: return "STOP ";
			8'd228: return "SLOW "; 8'd229: return "FAST "; 8'd230: return "NEW ";
			8'd231: return "SCROLL "; 8'd232: return "CONT "; 8'd233: return "DIM ";
			8'd234: return "REM "; 8'd235: return "FOR "; 8'd236: return "GOTO ";
			8'd237: return "GOSUB "; 8'd238: return "INPUT "; 8'd239: return "LOAD ";
			8'd240: return "LIST "; 8'd241: return "LET "; 8'd242: return "PAUSE ";
			8'd243: return "NEXT "; 8'd244: return "POKE "; 8'd245: return "PRINT ";
			8'd246: return "PLOT "; 8'd247: return "RUN "; 8'd248: return "SAVE ";
			8'd249: return "RAND "; 8'd250: return "IF "; 8'd251: return "CLS ";
			8'd252: return "UNPLOT "; 8'd253: return "CLEAR "; 8'd254: return "RETURN ";
			8'd255: return "COPY ";
			default: return "?";
		endcase
	endfunction

	// Digits and letters are computed; others come from the string table.
	function automatic logic [6:0] rom_char(input logic [7:0] b, input int idx);
		string s;
		logic [7:0] c;
		s = rom_text(b);
		c = 8'd0;
		if (b >= 8'd28 && b <= 8'd37) begin
			c = (idx == 0) ? 8'(b + 8'd20) : 8'd0;
		end else if (b >= 8'd38 && b <= 8'd63) begin
			c = (idx == 0) ? 8'(b + 8'd27) : 8'd0;
		end else if (b >= 8'd156 && b <= 8'd191) begin
			if (idx == 0) c = "[";
			else if (idx == 2) c = "]";
			else if (idx == 1) c = (b <= 8'd165) ? 8'(b - 8'd108) : 8'(b - 8'd101);
		end else if (idx < s.len()) begin
			c = s[idx];
		end
		return c[6:0];
	endfunction

	function automatic logic [CharIdxW-1:0] rom_len(input logic [7:0] b);
		int n;
		n = 0;
		for (int i = 0; i < MaxTokenChars; i++)
			if (rom_char(b, i) != 7'd0 && n == i) n = i + 1;
		return CharIdxW'(n);
	endfunction

endpackage

FILE: design/bpd_if.sv
// Valid/ready channel interface for the detokenizer.
// Depends on bpd_pkg for nothing; payload width is a parameter-free type.
interface bpd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface bpd_out_if;
	logic valid;
	logic ready;
	logic item_type;
	logic [15:0] line_number;
	logic [6:0] char_code;
	logic last_of_run;
	modport source (output valid, output item_type, output line_number, output char_code,
		output last_of_run, input ready);
	modport sink (input valid, input item_type, input line_number, input char_code,
		input last_of_run, output ready);
endinterface

FILE: design/bpd_datapath.sv
// Datapath: parse state, counters, latched byte and status register.
// Depends on bpd_pkg.
module bpd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	input  logic [7:0] in_byte,
	input  bpd_pkg::dp_cmd_t cmd,
	output bpd_pkg::dp_stat_t stat,
	output logic item_type,
	output logic [15:0] line_number,
	output logic [6:0] char_code,
	output logic last_of_run
);
	import bpd_pkg::*;

	phase_t phase_q;
	logic [15:0] program_end_q, position_q, current_line_q, line_length_q;
	logic [15:0] body_count_q, skip_q;
	logic [7:0] hi_q, byte_q;
	logic [CharIdxW-1:0] idx_q, len_q;
	logic [16:0] pos_inc, bc_inc, bc_inc5;
	logic [15:0] pos_sat, bc_sat, bc_sat5;

	assign pos_inc = {1'b0, position_q} + 17'd1;
	assign pos_sat = pos_inc[16] ? 16'hFFFF : pos_inc[15:0];
	assign bc_inc = {1'b0, body_count_q} + 17'd1;
	assign bc_sat = bc_inc[16] ? 16'hFFFF : bc_inc[15:0];
	assign bc_inc5 = {1'b0, bc_sat} + {1'b0, NumSkip};
	assign bc_sat5 = bc_inc5[16] ? 16'hFFFF : bc_inc5[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_end_q <= ProgramStart;
			phase_q <= PH_HDR0;
			position_q <= ProgramStart;
			hi_q <= '0;
			byte_q <= '0;
			current_line_q <= '0;
			line_length_q <= '0;
			body_count_q <= '0;
			skip_q <= '0;
			stat <= '0;
			idx_q <= '0;
			len_q <= '0;
		end else begin
			if (cfg_we) program_end_q <= cfg_data;
			stat.emit_line <= 1'b0;
			stat.char_count <= '0;
			if (cmd.next_char) idx_q <= idx_q + 1'b1;
			if (cmd.parse) begin
				byte_q <= in_byte;
				idx_q <= '0;
				case (phase_q)
					PH_HDR0: begin
						if (position_q >= program_end_q) phase_q <= PH_DONE;
						else begin
							hi_q <= in_byte;
							position_q <= pos_sat;
							phase_q <= PH_HDR1;
						end
					end
					PH_HDR1: begin
						current_line_q <= {hi_q, in_byte};
						position_q <= pos_sat;
						phase_q <= PH_HDR2;
					end
					PH_HDR2: begin
						line_length_q <= {8'd0, in_byte};
						position_q <= pos_sat;
						phase_q <= PH_HDR3;
					end
					PH_HDR3: begin
						line_length_q <= {in_byte, line_length_q[7:0]};
						position_q <= pos_sat;
						body_count_q <= '0;
						phase_q <= PH_BODY;
						stat.emit_line <= 1'b1;
					end
					PH_BODY: begin
						if (position_q >= program_end_q) phase_q <= PH_DONE;
						else begin
							position_q <= pos_sat;
							body_count_q <= bc_sat;
							if (in_byte == TokNewline) begin
								if (line_length_q > bc_sat) begin
									skip_q <= line_length_q - bc_sat;
									phase_q <= PH_SKIPLINE;
								end else phase_q <= PH_HDR0;
							end else if (in_byte == TokNumber) begin
								body_count_q <= bc_sat5;
								skip_q <= NumSkip;
								phase_q <= PH_SKIPNUM;
							end else begin
								stat.char_count <= rom_len(in_byte);
								len_q <= rom_len(in_byte);
							end
						end
					end
					PH_SKIPNUM, PH_SKIPLINE: begin
						position_q <= pos_sat;
						if (skip_q <= 16'd1) begin
							skip_q <= '0;
							phase_q <= (phase_q == PH_SKIPNUM) ? PH_BODY : PH_HDR0;
						end else skip_q <= skip_q - 16'd1;
					end
					default: phase_q <= PH_DONE;
				endcase
			end
		end
	end

	assign item_type = cmd.emit_char;
	assign line_number = cmd.emit_char ? 16'd0 : current_line_q;
	assign char_code = cmd.emit_char ? rom_char(byte_q, int'(idx_q)) : 7'd0;
	assign last_of_run = cmd.emit_char ? (idx_q + 1'b1 == len_q) : 1'b1;

`ifndef SYNTHESIS
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		stat.char_count <= CharIdxW'(MaxTokenChars)) else $error("length overflow");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE) else $error("left done");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_char |-> idx_q < len_q) else $error("index past token");
`endif
endmodule

FILE: design/bpd_ctrl.sv
// Controller: accepts requests, sequences result characters from the datapath.
// Depends on bpd_pkg.
module bpd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic out_is_char,
	input  bpd_pkg::dp_stat_t stat,
	input  logic last,
	output bpd_pkg::dp_cmd_t cmd
);
	import bpd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= in_valid && in_ready;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (pend_q && (stat.emit_line || stat.char_count != '0)) state_d = ST_EMIT;
			ST_EMIT: if (out_ready && last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// line result waits in emit until taken; char kind latched from status
	logic char_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) char_q <= 1'b0;
		else if (state_q == ST_IDLE && pend_q) char_q <= !stat.emit_line;
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE) && !pend_q;
		out_valid = (state_q == ST_EMIT);
		out_is_char = char_q;
		cmd.parse = in_valid && in_ready;
		cmd.emit_char = (state_q == ST_EMIT) && char_q;
		cmd.next_char = out_valid && out_ready && char_q && !last;
	end

`ifndef SYNTHESIS
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept during output");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.parse |=> !in_ready) else $error("back to back accept");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule

FILE: design/basic_program_detokenizer.sv
// Top level of the BASIC program detokenizer: controller plus datapath.
// Depends on bpd_pkg, bpd_if, bpd_ctrl, bpd_datapath.
//  channel  dir  payload
//  in       in   data_byte[7:0]
//  out      out  item_type, line_number[15:0], char_code[6:0], last_of_run
//  cfg      in   cfg_we, cfg_data[15:0] (program_end)
// A byte is parsed, then gives 0 to 10 results, sent one a cycle while the
// output is ready. Reset is asynchronous; no clearing pass.
// A stalled output holds the result and blocks new requests.
module basic_program_detokenizer (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	bpd_in_if.sink in,
	bpd_out_if.source out
);
	import bpd_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic is_char;
	logic it, lr;
	logic [15:0] ln;
	logic [6:0] cc;

	bpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready), .out_is_char(is_char),
		.stat(stat), .last(lr), .cmd(cmd)
	);

	bpd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_byte(in.data_byte), .cmd(cmd), .stat(stat), .item_type(it),
		.line_number(ln), .char_code(cc), .last_of_run(lr)
	);

	assign out.item_type = it && is_char;
	assign out.line_number = ln;
	assign out.char_code = cc;
	assign out.last_of_run = lr;
endmodule
